FILE: hdl/btm_pkg.sv
`timescale 1ns / 1ps

package btm_pkg;

	// Stream payload widths
	localparam int IN_DATA_W  = 40;  // music, noise, clear_phase, zero fill
	localparam int IN_USER_W  = 1;   // music_valid
	localparam int OUT_DATA_W = 32;  // left_out, right_out

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam int SAMPLE_W = 16;
	localparam int STEP_W   = 32;
	localparam int CARRIER_W = 31;
	localparam int AMP_W    = 16;
	localparam int MIX_W    = 17;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_CARRIER = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_AMP     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MIX     = 2'd3;

	localparam logic [AMP_W-1:0] AMP_RESET = 16'd32768;
	localparam logic [MIX_W-1:0] MIX_FULL  = 17'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TONE,
		ST_MASK,
		ST_MIX,
		ST_DONE
	} btm_state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_TONE,
		OP_MASK,
		OP_MIX
	} btm_op_t;

	typedef struct packed {
		logic    accept;
		btm_op_t op;
		logic    load_out;
	} btm_cmd_t;

endpackage

FILE: hdl/btm_ctrl.sv
`timescale 1ns / 1ps

module btm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output btm_pkg::btm_cmd_t cmd
);
	import btm_pkg::*;

	btm_state_t state_q;
	btm_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.op       = OP_NONE;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_TONE;
				end
			end
			ST_TONE: begin
				cmd.op  = OP_TONE;
				state_d = ST_MASK;
			end
			ST_MASK: begin
				cmd.op  = OP_MASK;
				state_d = ST_MIX;
			end
			ST_MIX: begin
				cmd.op  = OP_MIX;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					s_tready     = 1'b1;
					if (s_tvalid) begin
						cmd.accept = 1'b1;
						state_d    = ST_TONE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_accept_starts_tone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.op == OP_TONE)
		else $error("accepted transaction did not start the tone step");

	a_tone_then_mask: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_TONE |=> cmd.op == OP_MASK)
		else $error("mask step did not follow tone step");

	a_mask_then_mix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_MASK |=> cmd.op == OP_MIX)
		else $error("mix step did not follow mask step");

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("result loaded over an untaken result");
`endif

endmodule

FILE: hdl/btm_datapath.sv
`timescale 1ns / 1ps

module btm_datapath #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int PHASE_BITS       = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  btm_pkg::btm_cmd_t                   cmd,
	input  logic [btm_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [btm_pkg::IN_USER_W-1:0]       s_tuser,
	output logic [btm_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                cfg_we,
	input  logic [btm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [btm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import btm_pkg::*;

	localparam int AW      = $clog2(SINE_TABLE_DEPTH);
	localparam int ROM_W   = 15;
	localparam int MUL_W   = 18;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int MASKP_W = 35;
	localparam int ACC_W   = PROD_W + 1;

	typedef logic [ROM_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

	// Quarter-wave sine, Taylor series in Q30 evaluated at elaboration
	function automatic rom_t build_rom();
		rom_t                tbl;
		longint unsigned     x;
		longint unsigned     x2;
		longint unsigned     t;
		longint unsigned     s;
		longint unsigned     e;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x  = (64'd1686629713 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
			x2 = (x * x) >> 30;
			t  = 64'd1 << 30;
			t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd272);
			t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd210);
			t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd156);
			t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd110);
			t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
			t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
			t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
			t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
			s  = (x * t) >> 30;
			e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
			tbl[k] = (e > 64'd32767) ? ROM_W'(32767) : e[ROM_W-1:0];
		end
		return tbl;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Configuration registers
	logic [CARRIER_W-1:0] carrier_q;
	logic [STEP_W-1:0]    offset_q;
	logic [AMP_W-1:0]     amp_q;
	logic [MIX_W-1:0]     mix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= '0;
			offset_q  <= '0;
			amp_q     <= AMP_RESET;
			mix_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CARRIER: carrier_q <= cfg_wdata[CARRIER_W-1:0];
				REG_OFFSET:  offset_q  <= cfg_wdata[STEP_W-1:0];
				REG_AMP:     amp_q     <= cfg_wdata[AMP_W-1:0];
				REG_MIX:     mix_q     <= cfg_wdata[MIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	logic [MIX_W-1:0] mix_w;
	logic [MIX_W-1:0] tone_w;
	assign mix_w  = mix_q[MIX_W-1] ? MIX_FULL : mix_q;
	assign tone_w = MIX_W'(18'd65536 - {1'b0, mix_w});

	// Phase steps scaled to PHASE_BITS
	logic [STEP_W-1:0]     step_l32;
	logic [STEP_W-1:0]     step_r32;
	logic [PHASE_BITS-1:0] step_l;
	logic [PHASE_BITS-1:0] step_r;

	assign step_l32 = {1'b0, carrier_q};
	assign step_r32 = step_l32 + offset_q;

	generate
		if (PHASE_BITS >= STEP_W) begin : g_step_up
			assign step_l = PHASE_BITS'(step_l32) << (PHASE_BITS - STEP_W);
			assign step_r = PHASE_BITS'(step_r32) << (PHASE_BITS - STEP_W);
		end else begin : g_step_down
			assign step_l = PHASE_BITS'(step_l32 >> (STEP_W - PHASE_BITS));
			assign step_r = PHASE_BITS'(step_r32 >> (STEP_W - PHASE_BITS));
		end
	endgenerate

	// Input fields
	logic signed [SAMPLE_W-1:0] music;
	logic signed [SAMPLE_W-1:0] noise;
	logic                       clear;
	logic signed [SAMPLE_W:0]   mask_sum;

	assign music    = s_tuser[0] ? s_tdata[15:0] : '0;
	assign noise    = s_tdata[31:16];
	assign clear    = s_tdata[32];
	assign mask_sum = {music[SAMPLE_W-1], music} + {noise[SAMPLE_W-1], noise};

	// Phase accumulators and table addressing
	logic [PHASE_BITS-1:0] left_phase_q;
	logic [PHASE_BITS-1:0] right_phase_q;
	logic [PHASE_BITS-1:0] phase_l;
	logic [PHASE_BITS-1:0] phase_r;
	logic [AW+1:0]         frac_l;
	logic [AW+1:0]         frac_r;
	logic [AW:0]           addr_l;
	logic [AW:0]           addr_r;

	assign phase_l = clear ? '0 : left_phase_q;
	assign phase_r = clear ? '0 : right_phase_q;
	assign frac_l  = phase_l[PHASE_BITS-1 -: AW+2];
	assign frac_r  = phase_r[PHASE_BITS-1 -: AW+2];
	assign addr_l  = frac_l[AW] ? (AW+1)'(SINE_TABLE_DEPTH) - {1'b0, frac_l[AW-1:0]}
	                            : {1'b0, frac_l[AW-1:0]};
	assign addr_r  = frac_r[AW] ? (AW+1)'(SINE_TABLE_DEPTH) - {1'b0, frac_r[AW-1:0]}
	                            : {1'b0, frac_r[AW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_phase_q  <= '0;
			right_phase_q <= '0;
		end else if (cmd.accept) begin
			left_phase_q  <= phase_l + step_l;
			right_phase_q <= phase_r + step_r;
		end
	end

	logic [ROM_W-1:0]           rom_l_q;
	logic [ROM_W-1:0]           rom_r_q;
	logic                       neg_l_q;
	logic                       neg_r_q;
	logic signed [SAMPLE_W:0]   mask_sum_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rom_l_q    <= SINE_ROM[addr_l];
			rom_r_q    <= SINE_ROM[addr_r];
			neg_l_q    <= frac_l[AW+1];
			neg_r_q    <= frac_r[AW+1];
			mask_sum_q <= mask_sum;
		end
	end

	logic signed [SAMPLE_W-1:0] sine_l;
	logic signed [SAMPLE_W-1:0] sine_r;
	assign sine_l = neg_l_q ? -$signed({1'b0, rom_l_q}) : $signed({1'b0, rom_l_q});
	assign sine_r = neg_r_q ? -$signed({1'b0, rom_r_q}) : $signed({1'b0, rom_r_q});

	// One multiplier per channel, operands picked by the current step
	logic signed [MUL_W-1:0]  a_l;
	logic signed [MUL_W-1:0]  a_r;
	logic signed [MUL_W-1:0]  b_w;
	logic signed [PROD_W-1:0] prod_l_q;
	logic signed [PROD_W-1:0] prod_r_q;
	logic signed [MUL_W-1:0]  tone_l_q;
	logic signed [MUL_W-1:0]  tone_r_q;
	logic signed [MASKP_W-1:0] mask_prod_q;

	always_comb begin
		a_l = '0;
		a_r = '0;
		b_w = '0;
		case (cmd.op)
			OP_TONE: begin
				a_l = MUL_W'(sine_l);
				a_r = MUL_W'(sine_r);
				b_w = $signed({2'b00, amp_q});
			end
			OP_MASK: begin
				a_l = MUL_W'(mask_sum_q);
				a_r = MUL_W'(mask_sum_q);
				b_w = $signed({1'b0, mix_w});
			end
			OP_MIX: begin
				a_l = tone_l_q;
				a_r = tone_r_q;
				b_w = $signed({1'b0, tone_w});
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op != OP_NONE) begin
			prod_l_q <= a_l * b_w;
			prod_r_q <= a_r * b_w;
		end
		if (cmd.op == OP_MASK) begin
			tone_l_q <= MUL_W'((prod_l_q + PROD_W'(1 << 14)) >>> 15);
			tone_r_q <= MUL_W'((prod_r_q + PROD_W'(1 << 14)) >>> 15);
		end
		if (cmd.op == OP_MIX) begin
			mask_prod_q <= prod_l_q[MASKP_W-1:0];
		end
	end

	// Blend, round and saturate
	logic signed [ACC_W-1:0] acc_l;
	logic signed [ACC_W-1:0] acc_r;
	logic signed [ACC_W-17:0] sh_l;
	logic signed [ACC_W-17:0] sh_r;
	logic [SAMPLE_W-1:0]     sat_l;
	logic [SAMPLE_W-1:0]     sat_r;

	assign acc_l = ACC_W'(prod_l_q) + ACC_W'(mask_prod_q) + ACC_W'(1 << 15);
	assign acc_r = ACC_W'(prod_r_q) + ACC_W'(mask_prod_q) + ACC_W'(1 << 15);
	assign sh_l  = acc_l[ACC_W-1:16];
	assign sh_r  = acc_r[ACC_W-1:16];

	always_comb begin
		if (sh_l > $signed((ACC_W-16)'(32767))) begin
			sat_l = 16'h7fff;
		end else if (sh_l < -$signed((ACC_W-16)'(32768))) begin
			sat_l = 16'h8000;
		end else begin
			sat_l = sh_l[SAMPLE_W-1:0];
		end
		if (sh_r > $signed((ACC_W-16)'(32767))) begin
			sat_r = 16'h7fff;
		end else if (sh_r < -$signed((ACC_W-16)'(32768))) begin
			sat_r = 16'h8000;
		end else begin
			sat_r = sh_r[SAMPLE_W-1:0];
		end
	end

	logic [OUT_DATA_W-1:0] out_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= {sat_r, sat_l};
		end
	end

	assign m_tdata = out_q;

endmodule

FILE: hdl/binaural_tone_mixer.sv
`timescale 1ns / 1ps

// Two-tone oscillator with masking mixer.
// Input stream (s_*): one transaction per sample tick. tdata carries the music and
// noise samples and the clear_phase flag, tuser carries music_valid. The left tone
// runs at carrier_step, the right tone at carrier_step + offset_step; both are
// scaled by amplitude and blended with mix_level times (music + noise).
// Output stream (m_*): one transaction per input, left and right samples saturated
// to 16 bits, in input order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 carrier_step,
// 1 offset_step, 2 amplitude, 3 mix_level); write only while no sample is in flight.
// Each sample passes the tone, mask and mix steps, then its result loads into the
// output register; the three products share one multiplier per channel, one product
// per cycle, and the next sample is taken in the cycle the result loads.
// SINE_TABLE_DEPTH must be a power of two; the quarter-wave table is a ROM with
// registered read, addressed for both channels in the accept cycle.
// Reset clears both phases, restores the register defaults (amplitude full scale)
// and empties the output register. A stalled receiver holds the result in the
// output register; one more sample may be worked, then s_tready drops until m_tready.
module binaural_tone_mixer #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int PHASE_BITS       = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// write port
	input  logic                                cfg_we,
	input  logic [btm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [btm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// sample input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [15:0] music_sample, [31:16] noise_sample, [32] clear_phase, [39:33] zero
	input  logic [btm_pkg::IN_DATA_W-1:0]       s_tdata,
	// [0] music_valid
	input  logic [btm_pkg::IN_USER_W-1:0]       s_tuser,
	// mixed output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [15:0] left_out, [31:16] right_out
	output logic [btm_pkg::OUT_DATA_W-1:0]      m_tdata
);
	import btm_pkg::*;

	btm_cmd_t cmd;

	// Sequence accept, tone, mask, mix and output load
	btm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Phases, sine ROM, multipliers and output register
	btm_datapath #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.PHASE_BITS       (PHASE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

endmodule
